@@ hdl/cds_pkg.sv @@
// Shared types and constants for the critically damped 2-D smoother.
// Used by cds_arith and the top level critically_damped_smoother_2d_unit.
package cds_pkg;

  // Largest magnitude that any intermediate value may take.
  localparam logic [63:0] LIM = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  // Scaling applied to a finished product.
  typedef enum logic [1:0] {
    SH_FRAC = 2'd0,
    SH_30   = 2'd1,
    SH_RAW  = 2'd2
  } shift_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    shift_t      sh;
    logic        neg;
    logic [63:0] a;
    logic [63:0] b;
  } cmd_t;

  typedef struct packed {
    logic         done;
    logic [63:0]  res;
    logic [127:0] wide;
  } rsp_t;

endpackage

@@ hdl/cds_arith.sv @@
// Shared arithmetic unit: 64x64 multiplier built from 32x32 partials,
// restoring 64-bit divider and 64-bit integer square root. Uses cds_pkg.
module cds_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cds_pkg::cmd_t cmd_i,
  output cds_pkg::rsp_t rsp_o
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_DIV  = 5'b00100,
    A_SQRT = 5'b01000,
    A_FIN  = 5'b10000
  } astate_t;

  astate_t          astate_r, astate_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  cds_pkg::op_t     op_r, op_nxt;
  cds_pkg::shift_t  sh_r, sh_nxt;
  logic             neg_r, neg_nxt;
  logic [63:0]      a_r, a_nxt;
  logic [63:0]      b_r, b_nxt;
  logic [127:0]     acc_r, acc_nxt;
  logic [63:0]      part_r, part_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [64:0]      rem_r, rem_nxt;
  logic [63:0]      res_r, res_nxt;
  logic             done_r, done_nxt;

  logic [31:0]  mop_a, mop_b;
  logic [127:0] part_sh;
  logic [64:0]  dsh, ssh, trial;
  logic         dge, sge;
  logic [63:0]  u_frac, u_30, u_sel, u_sat;

  always_comb begin
    mop_a = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    mop_b = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    case (pos_r)
      2'd0:    part_sh = {64'd0, part_r};
      2'd1:    part_sh = {32'd0, part_r, 32'd0};
      default: part_sh = {part_r, 64'd0};
    endcase
    dsh   = {rem_r[63:0], a_r[63]};
    dge   = dsh >= {1'b0, b_r};
    ssh   = {rem_r[62:0], a_r[63:62]};
    trial = {31'd0, b_r[31:0], 2'b01};
    sge   = ssh >= trial;
    // In the FRAC and 30-bit scalings a product that does not fit pins to all ones.
    u_frac = (|acc_r[127:64+FRAC_BITS]) ? '1 : acc_r[63+FRAC_BITS:FRAC_BITS];
    u_30   = (|acc_r[127:94]) ? '1 : acc_r[93:30];
    case (sh_r)
      cds_pkg::SH_FRAC: u_sel = u_frac;
      cds_pkg::SH_30:   u_sel = u_30;
      default:          u_sel = acc_r[63:0];
    endcase
    u_sat = (u_sel > cds_pkg::LIM) ? cds_pkg::LIM : u_sel;
  end

  always_comb begin
    astate_nxt = astate_r;
    cnt_nxt    = cnt_r + 6'd1;
    op_nxt     = op_r;
    sh_nxt     = sh_r;
    neg_nxt    = neg_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    part_nxt   = part_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    case (astate_r)
      A_IDLE: begin
        cnt_nxt = 6'd0;
        if (cmd_i.start) begin
          op_nxt  = cmd_i.op;
          sh_nxt  = cmd_i.sh;
          neg_nxt = cmd_i.neg;
          a_nxt   = cmd_i.a;
          b_nxt   = (cmd_i.op == cds_pkg::OP_SQRT) ? 64'd0 : cmd_i.b;
          acc_nxt = '0;
          rem_nxt = '0;
          case (cmd_i.op)
            cds_pkg::OP_MUL:  astate_nxt = A_MUL;
            cds_pkg::OP_DIV:  astate_nxt = A_DIV;
            default:          astate_nxt = A_SQRT;
          endcase
        end
      end
      A_MUL: begin
        // Partial i is formed while partial i-1 is added in.
        part_nxt = 64'(mop_a * mop_b);
        pos_nxt  = {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
        if (cnt_r != 6'd0) acc_nxt = acc_r + part_sh;
        if (cnt_r == 6'd4) astate_nxt = A_FIN;
      end
      A_DIV: begin
        rem_nxt = dge ? (dsh - {1'b0, b_r}) : dsh;
        a_nxt   = {a_r[62:0], dge};
        if (cnt_r == 6'd63) astate_nxt = A_FIN;
      end
      A_SQRT: begin
        rem_nxt = sge ? (ssh - trial) : ssh;
        a_nxt   = {a_r[61:0], 2'b00};
        b_nxt   = {32'd0, b_r[30:0], sge};
        if (cnt_r == 6'd31) astate_nxt = A_FIN;
      end
      A_FIN: begin
        case (op_r)
          cds_pkg::OP_MUL:  res_nxt = neg_r ? (64'd0 - u_sat) : u_sat;
          cds_pkg::OP_DIV:  res_nxt = a_r;
          default:          res_nxt = b_r;
        endcase
        done_nxt   = 1'b1;
        astate_nxt = A_IDLE;
      end
      default: astate_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      astate_r <= A_IDLE;
      done_r   <= 1'b0;
    end else begin
      astate_r <= astate_nxt;
      done_r   <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    op_r   <= op_nxt;
    sh_r   <= sh_nxt;
    neg_r  <= neg_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    part_r <= part_nxt;
    pos_r  <= pos_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.res  = res_r;
  assign rsp_o.wide = acc_r;

endmodule

@@ hdl/critically_damped_smoother_2d_unit.sv @@
// Top level of the critically damped 2-D smoother: APB registers, stream
// ports and the step sequencer. Depends on cds_pkg and cds_arith.

// One beat in produces one beat out. The sequencer runs every multiply,
// divide and square root through one shared unit; the 64-bit divider yields
// one quotient bit per cycle. The divider is used two to six times per beat:
// twice always, once more when the spring factor is small enough to need the
// exponential, once more when the length limit acts and twice more when the
// overshoot snap acts. in_tready is high only while the block is idle; a
// finished result waits in the output register, so the next beat can be
// taken while the previous result is still pending. Velocity is kept between
// beats and cleared by reset.
module critically_damped_smoother_2d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // current_x, current_y, target_x, target_y
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // smoothed_x, smoothed_y, speed_x, speed_y
  output logic         out_tuser,  // snapped
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MIN_RAW  = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [30:0] MIN_ST   = (MIN_RAW == 64'd0) ? 31'd1 : 31'(MIN_RAW);
  localparam logic [63:0] C48      = ((64'd48 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] C235     = ((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [63:0] OMEGA_NUM = 64'd1 << (2 * FRAC_BITS + 1);
  localparam logic [63:0] E_ONE    = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] X_LIM    = 64'd1 << (FRAC_BITS + 10);

  localparam logic [1:0] REG_SMOOTH = 2'd0;
  localparam logic [1:0] REG_SPEED  = 2'd1;
  localparam logic [1:0] REG_DT     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef enum logic [27:0] {
    ST_OMEGA = 28'h000_0001, ST_X    = 28'h000_0002, ST_X2   = 28'h000_0004,
    ST_X3    = 28'h000_0008, ST_T1   = 28'h000_0010, ST_T2   = 28'h000_0020,
    ST_E     = 28'h000_0040, ST_MC   = 28'h000_0080, ST_SQX  = 28'h000_0100,
    ST_SQY   = 28'h000_0200, ST_SQRT = 28'h000_0400, ST_R    = 28'h000_0800,
    ST_LX    = 28'h000_1000, ST_LY   = 28'h000_2000, ST_PAX  = 28'h000_4000,
    ST_PBX   = 28'h000_8000, ST_PAY  = 28'h001_0000, ST_PBY  = 28'h002_0000,
    ST_VAX   = 28'h004_0000, ST_VBX  = 28'h008_0000, ST_VAY  = 28'h010_0000,
    ST_VBY   = 28'h020_0000, ST_OX   = 28'h040_0000, ST_OY   = 28'h080_0000,
    ST_DOT1  = 28'h100_0000, ST_DOT2 = 28'h200_0000, ST_SVX  = 28'h400_0000,
    ST_SVY   = 28'h800_0000
  } step_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    s   = {a[63], a} + {b[63], b};
    lim = {1'b0, cds_pkg::LIM};
    if (s > lim) return $signed(cds_pkg::LIM);
    else if (s < -lim) return $signed(64'd0 - cds_pkg::LIM);
    else return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    else if (v < -64'sh8000_0000) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [30:0] smooth_time_r, max_speed_r, delta_time_r;
  logic [31:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [31:0] vel_x_r, vel_y_r;
  logic [63:0] omega_r, x_r, x2_r, x3_r, p_r, e_r, mc_r, r_r, sq_r, len_r;
  logic signed [63:0] cx_r, cy_r, s_r, px_r, py_r, vx_r, vy_r, ox_r, oy_r;
  logic [32:0]  ax_r, ay_r;
  logic         k_r;
  logic [127:0] w_r;
  logic         snap_r;
  logic [127:0] out_tdata_r;
  logic         out_tuser_r, out_tvalid_r;

  cds_pkg::cmd_t cmd;
  cds_pkg::rsp_t rsp;

  logic        in_acc, cfg_wr, ld_out, wdone;
  logic [30:0] st, dt;
  logic signed [32:0] in_cx, in_cy, dx, dy;
  logic [32:0] in_ax, in_ay, adx, ady;
  logic [63:0] axs, ays, len_calc;
  logic signed [63:0] sum_x, sum_y, b1, b2;
  logic        z1, z2, n1, n2, snap_calc;

  cds_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign wdone      = (state_r == S_WAIT) && rsp.done;
  assign ld_out     = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SMOOTH: cfg_prdata = {1'b0, smooth_time_r};
      REG_SPEED:  cfg_prdata = {1'b0, max_speed_r};
      REG_DT:     cfg_prdata = {1'b0, delta_time_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    st    = (smooth_time_r > MIN_ST) ? smooth_time_r : MIN_ST;
    dt    = (delta_time_r == 31'd0) ? 31'd1 : delta_time_r;
    in_cx = $signed({in_tdata[31], in_tdata[31:0]}) - $signed({in_tdata[95], in_tdata[95:64]});
    in_cy = $signed({in_tdata[63], in_tdata[63:32]})
          - $signed({in_tdata[127], in_tdata[127:96]});
    in_ax = in_cx[32] ? (33'd0 - in_cx) : in_cx;
    in_ay = in_cy[32] ? (33'd0 - in_cy) : in_cy;
    dx    = $signed({tgt_x_r[31], tgt_x_r}) - $signed({cur_x_r[31], cur_x_r});
    dy    = $signed({tgt_y_r[31], tgt_y_r}) - $signed({cur_y_r[31], cur_y_r});
    adx   = dx[32] ? (33'd0 - dx) : dx;
    ady   = dy[32] ? (33'd0 - dy) : dy;
    axs   = k_r ? {33'd0, ax_r[32:2]} : {31'd0, ax_r};
    ays   = k_r ? {33'd0, ay_r[32:2]} : {31'd0, ay_r};
    sum_x = sadd(cx_r, px_r);
    sum_y = sadd(cy_r, py_r);
    b1    = ox_r - sx32(tgt_x_r);
    b2    = oy_r - sx32(tgt_y_r);
    len_calc = k_r ? {rsp.res[61:0], 2'b00} : rsp.res;
    // Sign of the dot product of (target - current) and (output - target),
    // decided from term signs first and from the exact products only when
    // the two terms disagree.
    z1 = (dx == 33'sd0) || (b1 == 64'sd0);
    z2 = (dy == 33'sd0) || (b2 == 64'sd0);
    n1 = dx[32] ^ b1[63];
    n2 = dy[32] ^ b2[63];
    if (z1) snap_calc = !z2 && !n2;
    else if (z2 || (n1 == n2)) snap_calc = !n1;
    else if (!n1) snap_calc = w_r > rsp.wide;
    else snap_calc = rsp.wide > w_r;
  end

  // Operands for the shared unit follow the current step.
  always_comb begin
    cmd.start = (state_r == S_ISSUE);
    cmd.op    = cds_pkg::OP_MUL;
    cmd.sh    = cds_pkg::SH_FRAC;
    cmd.neg   = 1'b0;
    cmd.a     = 64'd0;
    cmd.b     = 64'd0;
    case (step_r)
      ST_OMEGA: begin
        cmd.op = cds_pkg::OP_DIV; cmd.a = OMEGA_NUM; cmd.b = {33'd0, st};
      end
      ST_X: begin
        cmd.op = cds_pkg::OP_DIV; cmd.a = {33'd0, dt} << (FRAC_BITS + 1);
        cmd.b  = {33'd0, st};
      end
      ST_X2: begin cmd.a = x_r;  cmd.b = x_r; end
      ST_X3: begin cmd.a = x2_r; cmd.b = x_r; end
      ST_T1: begin cmd.a = C48;  cmd.b = x2_r; end
      ST_T2: begin cmd.a = C235; cmd.b = x3_r; end
      ST_E: begin
        cmd.op = cds_pkg::OP_DIV; cmd.a = E_ONE + (p_r >> 1); cmd.b = p_r;
      end
      ST_MC:  begin cmd.a = {33'd0, max_speed_r}; cmd.b = {33'd0, st}; end
      ST_SQX: begin cmd.sh = cds_pkg::SH_RAW; cmd.a = axs; cmd.b = axs; end
      ST_SQY: begin cmd.sh = cds_pkg::SH_RAW; cmd.a = ays; cmd.b = ays; end
      ST_SQRT: begin cmd.op = cds_pkg::OP_SQRT; cmd.a = sq_r; end
      ST_R: begin
        cmd.op = cds_pkg::OP_DIV; cmd.a = {mc_r[33:0], 30'd0}; cmd.b = len_r;
      end
      ST_LX: begin
        cmd.sh = cds_pkg::SH_30; cmd.a = {31'd0, ax_r}; cmd.b = r_r; cmd.neg = cx_r[63];
      end
      ST_LY: begin
        cmd.sh = cds_pkg::SH_30; cmd.a = {31'd0, ay_r}; cmd.b = r_r; cmd.neg = cy_r[63];
      end
      ST_PAX: begin cmd.a = omega_r; cmd.b = mag64(cx_r); cmd.neg = cx_r[63]; end
      ST_PAY: begin cmd.a = omega_r; cmd.b = mag64(cy_r); cmd.neg = cy_r[63]; end
      ST_PBX, ST_PBY: begin
        cmd.a = mag64(s_r); cmd.b = {33'd0, dt}; cmd.neg = s_r[63];
      end
      ST_VAX: begin cmd.a = omega_r; cmd.b = mag64(px_r); cmd.neg = px_r[63]; end
      ST_VAY: begin cmd.a = omega_r; cmd.b = mag64(py_r); cmd.neg = py_r[63]; end
      ST_VBX, ST_VBY: begin cmd.a = mag64(s_r); cmd.b = e_r; cmd.neg = s_r[63]; end
      ST_OX: begin cmd.a = mag64(sum_x); cmd.b = e_r; cmd.neg = sum_x[63]; end
      ST_OY: begin cmd.a = mag64(sum_y); cmd.b = e_r; cmd.neg = sum_y[63]; end
      ST_DOT1: begin cmd.sh = cds_pkg::SH_RAW; cmd.a = {31'd0, adx}; cmd.b = mag64(b1); end
      ST_DOT2: begin cmd.sh = cds_pkg::SH_RAW; cmd.a = {31'd0, ady}; cmd.b = mag64(b2); end
      ST_SVX: begin
        cmd.op = cds_pkg::OP_DIV; cmd.a = {31'd0, adx} << FRAC_BITS; cmd.b = {33'd0, dt};
      end
      ST_SVY: begin
        cmd.op = cds_pkg::OP_DIV; cmd.a = {31'd0, ady} << FRAC_BITS; cmd.b = {33'd0, dt};
      end
      default: cmd.a = 64'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ISSUE;
          step_nxt  = ST_OMEGA;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (rsp.done) begin
          state_nxt = S_ISSUE;
          case (step_r)
            ST_OMEGA: step_nxt = ST_X;
            ST_X:     step_nxt = (rsp.res < X_LIM) ? ST_X2 : ST_MC;
            ST_X2:    step_nxt = ST_X3;
            ST_X3:    step_nxt = ST_T1;
            ST_T1:    step_nxt = ST_T2;
            ST_T2:    step_nxt = ST_E;
            ST_E:     step_nxt = ST_MC;
            ST_MC:    step_nxt = ST_SQX;
            ST_SQX:   step_nxt = ST_SQY;
            ST_SQY:   step_nxt = ST_SQRT;
            ST_SQRT:  step_nxt = (len_calc > mc_r) ? ST_R : ST_PAX;
            ST_R:     step_nxt = ST_LX;
            ST_LX:    step_nxt = ST_LY;
            ST_LY:    step_nxt = ST_PAX;
            ST_PAX:   step_nxt = ST_PBX;
            ST_PBX:   step_nxt = ST_PAY;
            ST_PAY:   step_nxt = ST_PBY;
            ST_PBY:   step_nxt = ST_VAX;
            ST_VAX:   step_nxt = ST_VBX;
            ST_VBX:   step_nxt = ST_VAY;
            ST_VAY:   step_nxt = ST_VBY;
            ST_VBY:   step_nxt = ST_OX;
            ST_OX:    step_nxt = ST_OY;
            ST_OY:    step_nxt = ST_DOT1;
            ST_DOT1:  step_nxt = ST_DOT2;
            ST_DOT2: begin
              if (snap_calc) step_nxt = ST_SVX;
              else state_nxt = S_DONE;
            end
            ST_SVX:   step_nxt = ST_SVY;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_DONE: if (ld_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      step_r        <= ST_OMEGA;
      smooth_time_r <= 31'd19661;
      max_speed_r   <= 31'h7FFF_FFFF;
      delta_time_r  <= 31'd1092;
      vel_x_r       <= 32'd0;
      vel_y_r       <= 32'd0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_SMOOTH: smooth_time_r <= cfg_pwdata[30:0];
          REG_SPEED:  max_speed_r   <= cfg_pwdata[30:0];
          REG_DT:     delta_time_r  <= cfg_pwdata[30:0];
          default:    ;
        endcase
      end
      if (ld_out) begin
        vel_x_r      <= sat32(vx_r);
        vel_y_r      <= sat32(vy_r);
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_x_r <= in_tdata[31:0];
      cur_y_r <= in_tdata[63:32];
      tgt_x_r <= in_tdata[95:64];
      tgt_y_r <= in_tdata[127:96];
      cx_r    <= {{31{in_cx[32]}}, in_cx};
      cy_r    <= {{31{in_cy[32]}}, in_cy};
      ax_r    <= in_ax;
      ay_r    <= in_ay;
      k_r     <= in_ax[32] | in_ax[31] | in_ay[32] | in_ay[31];
    end
    if (ld_out) begin
      out_tdata_r[31:0]   <= snap_r ? tgt_x_r : sat32(ox_r);
      out_tdata_r[63:32]  <= snap_r ? tgt_y_r : sat32(oy_r);
      out_tdata_r[95:64]  <= sat32(vx_r);
      out_tdata_r[127:96] <= sat32(vy_r);
      out_tuser_r         <= snap_r;
    end
    if (wdone) begin
      case (step_r)
        ST_OMEGA: omega_r <= rsp.res;
        ST_X: begin
          x_r <= rsp.res;
          if (rsp.res >= X_LIM) e_r <= 64'd0;
        end
        ST_X2:   x2_r <= rsp.res;
        ST_X3:   x3_r <= rsp.res;
        ST_T1:   p_r  <= ONE_Q + x_r + rsp.res;
        ST_T2:   p_r  <= p_r + rsp.res;
        ST_E:    e_r  <= rsp.res;
        ST_MC:   mc_r <= rsp.res;
        ST_SQX:  sq_r <= rsp.res;
        ST_SQY:  sq_r <= sq_r + rsp.res;
        ST_SQRT: len_r <= len_calc;
        ST_R:    r_r  <= rsp.res;
        ST_LX:   cx_r <= rsp.res;
        ST_LY:   cy_r <= rsp.res;
        ST_PAX:  s_r  <= sadd(sx32(vel_x_r), rsp.res);
        ST_PBX:  px_r <= rsp.res;
        ST_PAY:  s_r  <= sadd(sx32(vel_y_r), rsp.res);
        ST_PBY:  py_r <= rsp.res;
        ST_VAX:  s_r  <= sadd(sx32(vel_x_r), 64'd0 - rsp.res);
        ST_VBX:  vx_r <= rsp.res;
        ST_VAY:  s_r  <= sadd(sx32(vel_y_r), 64'd0 - rsp.res);
        ST_VBY:  vy_r <= rsp.res;
        ST_OX:   ox_r <= sadd(sx32(cur_x_r) - cx_r, rsp.res);
        ST_OY:   oy_r <= sadd(sx32(cur_y_r) - cy_r, rsp.res);
        ST_DOT1: w_r  <= rsp.wide;
        ST_DOT2: snap_r <= snap_calc;
        ST_SVX:  vx_r <= dx[32] ? (64'd0 - rsp.res) : rsp.res;
        ST_SVY:  vy_r <= dy[32] ? (64'd0 - rsp.res) : rsp.res;
        default: ;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_WAIT)
    else $error("arith result arrived while sequencer was not waiting");

  a_vel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ld_out |=> $stable(vel_x_r) && $stable(vel_y_r))
    else $error("velocity changed outside of result load");

  a_snap_out: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out && snap_r |=> out_tuser_r && (out_tdata_r[31:0] == $past(tgt_x_r)))
    else $error("snapped result does not sit on the target");

endmodule
